### hw/rtl/qds_pkg.sv
// Package: shared types, register map, codes and helpers for the quadrature decoder.
package qds_pkg;

    // Register map (byte address = 4 * index).
    localparam int CFG_ADDR_W = 4;
    localparam logic [1:0] REG_TICK_RATE     = 2'd0;
    localparam logic [1:0] REG_WINDOW_TICKS  = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

    localparam logic [29:0] FREQ_RESET    = 30'd90000000;
    localparam logic [31:0] WINDOW_RESET  = 32'd22500000;
    localparam logic [31:0] TIMEOUT_RESET = 32'd45000000;

    localparam int TIMER_BITS_DEFAULT = 32;

    // Quotient bits produced by the divider once the saturation check passes.
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic MODE_SAMPLE  = 1'b0;
    localparam logic MODE_RESTART = 1'b1;

    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_CHANGED = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;
    localparam logic [1:0] ST_SPEED   = 2'd3;

    localparam logic [1:0] DIR_IDLE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BWD  = 2'd2;

    // Gray step codes: one ahead, one back.
    localparam logic [1:0] STEP_AHEAD = 2'd1;
    localparam logic [1:0] STEP_BACK  = 2'd3;

    typedef struct packed {
        logic        mode;
        logic [1:0]  pins;
        logic [31:0] timestamp;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         direction;
        logic signed [31:0] angle_tenths;
        logic [31:0]        speed_tenths;
    } out_word_t;

    typedef struct packed {
        logic [29:0] tick_rate;
        logic [31:0] window_ticks;
        logic [31:0] timeout_ticks;
    } cfg_t;

    // Position in the Gray order 00,01,11,10.
    function automatic logic [1:0] gray_index(input logic [1:0] p);
        gray_index = {p[1], p[1] ^ p[0]};
    endfunction

    // count * 3, saturated to 32 bits signed.
    function automatic logic signed [31:0] angle_of(input logic signed [31:0] count);
        logic signed [33:0] ext;
        logic signed [33:0] x3;
        ext = 34'(count);
        x3 = (ext <<< 1) + ext;
        if ((x3[33:31] == 3'b000) || (x3[33:31] == 3'b111))
        begin
            angle_of = x3[31:0];
        end
        else if (x3[33])
        begin
            angle_of = 32'sh8000_0000;
        end
        else
        begin
            angle_of = 32'sh7FFF_FFFF;
        end
    endfunction

endpackage

### hw/rtl/quadrature_decoder_speed.sv
// Top level: quadrature decoder with angle and speed, APB configuration.
//
//  channel   handshake                      word / data
//  item      item_valid / item_ready        item   (mode, pins, timestamp)
//  result    result_valid / result_ready    result (status, direction, angle, speed)
//  config    psel, penable, pwrite, pready  paddr, pwdata, prdata
//
//  One word at a time; states from acceptance back to item_ready:
//    restart ELAPSED, DONE; sample without phase change ELAPSED, TOCMP, DONE;
//    phase change ELAPSED, CLASS, WINCMP, DONE; a speed update adds MUL, SAT, DIV
//    (DIV: 32-step restoring divide on the shared subtractor; skipped on saturation).
//  The result sits in an output register; a stalled result only blocks the
//  next word's final step, not its acceptance.
//  rst_n is asynchronous, active low; it clears counts, direction, speed and
//  restores the configuration register defaults.
module quadrature_decoder_speed
    import qds_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // input words
    input  logic                  item_valid,
    output logic                  item_ready,
    input  in_word_t              item,

    // result words
    output logic                  result_valid,
    input  logic                  result_ready,
    output out_word_t             result,

    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t cfg;

    // register file: frequency, window length, timeout
    qds_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer with the shared subtractor; timer arithmetic is TIMER_BITS wide
    qds_core #(.TIMER_BITS(TIMER_BITS)) u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg          (cfg)
    );

endmodule

### hw/rtl/qds_alu.sv
// Shared subtractor/comparator used by the elapsed, compare, saturation and divide steps of the sequencer.
module qds_alu
    import qds_pkg::*;
#(
    parameter int AW = 33
)
(
    input  logic [AW-1:0] a,
    input  logic [AW-1:0] b,
    output logic [AW-1:0] diff,
    output logic          ge
);

    logic [AW:0] wide;

    assign wide = {1'b0, a} - {1'b0, b};
    assign diff = wide[AW-1:0];
    assign ge   = ~wide[AW];

endmodule

### hw/rtl/qds_cfg.sv
// APB register file: tick rate, window and timeout.
module qds_cfg
    import qds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [29:0] freq_reg;
    logic [31:0] window_reg;
    logic [31:0] timeout_reg;
    logic [1:0]  index;
    logic        wr_en;

    assign index  = paddr[CFG_ADDR_W-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg    <= FREQ_RESET;
            window_reg  <= WINDOW_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            case (index)
                REG_TICK_RATE:     freq_reg    <= pwdata[29:0];
                REG_WINDOW_TICKS:  window_reg  <= pwdata;
                REG_TIMEOUT_TICKS: timeout_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_TICK_RATE:     prdata = {2'b00, freq_reg};
            REG_WINDOW_TICKS:  prdata = window_reg;
            REG_TIMEOUT_TICKS: prdata = timeout_reg;
            default:           prdata = '0;
        endcase
    end

    assign cfg.tick_rate     = freq_reg;
    assign cfg.window_ticks  = window_reg;
    assign cfg.timeout_ticks = timeout_reg;

endmodule

### hw/rtl/qds_core.sv
// Decoder sequencer: phase classification, counts, window logic and iterative speed divide.
module qds_core
    import qds_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_word_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_word_t result,
    input  cfg_t      cfg
);

    localparam int EW = (TIMER_BITS > 32) ? TIMER_BITS : 32;
    localparam int AW = EW + 1;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_ELAPSED = 9'b000000010,
        S_CLASS   = 9'b000000100,
        S_TOCMP   = 9'b000001000,
        S_WINCMP  = 9'b000010000,
        S_MUL     = 9'b000100000,
        S_SAT     = 9'b001000000,
        S_DIV     = 9'b010000000,
        S_DONE    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // architectural state
    logic [1:0]            prev_reg, prev_next;
    logic [TIMER_BITS-1:0] wstart_reg, wstart_next;
    logic [31:0]           count_reg, count_next;
    logic [31:0]           trans_reg, trans_next;
    logic [1:0]            dir_reg, dir_next;
    logic [31:0]           speed_reg, speed_next;
    logic [1:0]            status_reg, status_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  result_valid_reg, result_valid_next;

    // working registers
    in_word_t              item_reg, item_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next;
    logic [63:0]           num_reg, num_next;
    logic [EW-1:0]         rem_reg, rem_next;
    logic [31:0]           quo_reg, quo_next;
    out_word_t             result_reg, result_next;

    logic [AW-1:0]         alu_a, alu_b, alu_diff;
    logic                  alu_ge;
    logic [TIMER_BITS-1:0] now;
    logic [1:0]            phase;
    logic [1:0]            step;
    logic [33:0]           trans_x3;
    logic [63:0]           product;
    logic [AW-1:0]         shifted;
    logic                  load_out;

    qds_alu #(.AW(AW)) u_alu
    (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .ge   (alu_ge)
    );

    assign now      = TIMER_BITS'(item_reg.timestamp);
    assign phase    = item_reg.pins;
    assign step     = gray_index(phase) - gray_index(prev_reg);
    assign trans_x3 = {trans_reg, 1'b0} + 34'(trans_reg);
    assign product  = 64'(trans_x3) * 64'(cfg.tick_rate);
    assign shifted  = {rem_reg, quo_reg[31]};
    assign load_out = (state_reg == S_DONE) && (!result_valid_reg || result_ready);

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // operand select for the shared unit
    always_comb
    begin
        case (state_reg)
            S_ELAPSED:
            begin
                alu_a = AW'(now);
                alu_b = AW'(wstart_reg);
            end
            S_WINCMP:
            begin
                alu_a = AW'(elapsed_reg);
                alu_b = AW'(cfg.window_ticks);
            end
            S_TOCMP:
            begin
                alu_a = AW'(elapsed_reg);
                alu_b = AW'(cfg.timeout_ticks);
            end
            S_SAT:
            begin
                alu_a = AW'(num_reg[63:32]);
                alu_b = AW'(elapsed_reg);
            end
            S_DIV:
            begin
                alu_a = shifted;
                alu_b = AW'(elapsed_reg);
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        prev_next         = prev_reg;
        wstart_next       = wstart_reg;
        count_next        = count_reg;
        trans_next        = trans_reg;
        dir_next          = dir_reg;
        speed_next        = speed_reg;
        status_next       = status_reg;
        cnt_next          = cnt_reg;
        item_next         = item_reg;
        elapsed_next      = elapsed_reg;
        num_next          = num_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    state_next = S_ELAPSED;
                end
            end
            S_ELAPSED:
            begin
                elapsed_next = alu_diff[TIMER_BITS-1:0];
                status_next  = ST_NONE;
                if (item_reg.mode == MODE_RESTART)
                begin
                    prev_next   = phase;
                    wstart_next = now;
                    count_next  = '0;
                    trans_next  = '0;
                    state_next  = S_DONE;
                end
                else if (phase != prev_reg)
                begin
                    state_next = S_CLASS;
                end
                else
                begin
                    state_next = S_TOCMP;
                end
            end
            S_CLASS:
            begin
                if (trans_reg != '1)
                begin
                    trans_next = trans_reg + 32'd1;
                end
                if (step == STEP_AHEAD)
                begin
                    dir_next    = DIR_FWD;
                    count_next  = count_reg + 32'd1;
                    status_next = ST_CHANGED;
                end
                else if (step == STEP_BACK)
                begin
                    dir_next    = DIR_BWD;
                    count_next  = count_reg - 32'd1;
                    status_next = ST_CHANGED;
                end
                else
                begin
                    status_next = ST_ILLEGAL;
                end
                prev_next  = phase;
                state_next = S_WINCMP;
            end
            S_WINCMP:
            begin
                if (!alu_ge)
                begin
                    state_next = S_DONE;
                end
                else if (elapsed_reg == '0)
                begin
                    status_next = ST_ILLEGAL;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_TOCMP:
            begin
                if (alu_ge)
                begin
                    speed_next  = '0;
                    wstart_next = now;
                    trans_next  = '0;
                    status_next = ST_SPEED;
                end
                state_next = S_DONE;
            end
            S_MUL:
            begin
                num_next   = product;
                state_next = S_SAT;
            end
            S_SAT:
            begin
                if (alu_ge)
                begin
                    // quotient would not fit in 32 bits
                    speed_next  = '1;
                    wstart_next = now;
                    trans_next  = '0;
                    status_next = ST_SPEED;
                    state_next  = S_DONE;
                end
                else
                begin
                    rem_next   = EW'(num_reg[63:32]);
                    quo_next   = num_reg[31:0];
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = alu_ge ? alu_diff[EW-1:0] : shifted[EW-1:0];
                quo_next = {quo_reg[30:0], alu_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    cnt_next    = '0;
                    speed_next  = {quo_reg[30:0], alu_ge};
                    wstart_next = now;
                    trans_next  = '0;
                    status_next = ST_SPEED;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    result_next.status       = status_reg;
                    result_next.direction    = dir_reg;
                    result_next.angle_tenths = angle_of(count_reg);
                    result_next.speed_tenths = speed_reg;
                    result_valid_next        = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            prev_reg         <= '0;
            wstart_reg       <= '0;
            count_reg        <= '0;
            trans_reg        <= '0;
            dir_reg          <= DIR_IDLE;
            speed_reg        <= '0;
            status_reg       <= ST_NONE;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            prev_reg         <= prev_next;
            wstart_reg       <= wstart_next;
            count_reg        <= count_next;
            trans_reg        <= trans_next;
            dir_reg          <= dir_next;
            speed_reg        <= speed_next;
            status_reg       <= status_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        elapsed_reg <= elapsed_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        result_reg  <= result_next;
    end

`ifndef SYNTH
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < EW'(elapsed_reg)))
        else $error("divider remainder not below elapsed");

    a_window_cleared_on_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && (status_reg == ST_SPEED)) |-> (trans_reg == '0))
        else $error("speed update left transitions in window");

    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.direction != 2'd3))
        else $error("bad direction code in result");

    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_DIV) |-> (cnt_reg == '0))
        else $error("divide step counter running outside divide");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> $stable(result))
        else $error("result word changed while stalled");
`endif

endmodule
